### hw/rtl/dwq_pkg.sv
// ---------------------------------------------------------------------------
// dwq_pkg
// Shared types and codes of the deferred work queue.
// ---------------------------------------------------------------------------
package dwq_pkg;

  localparam int DEF_RING_DEPTH   = 16;
  localparam int DEF_USABLE_DEPTH = 15;
  localparam int DEF_LINE_COUNT   = 16;
  localparam int DEF_WORK_SLOTS   = 16;

  localparam logic [7:0] NO_LINE = 8'd255;

  // modes
  localparam logic [2:0] M_INIT     = 3'd0;
  localparam logic [2:0] M_SCHEDULE = 3'd1;
  localparam logic [2:0] M_CANCEL   = 3'd2;
  localparam logic [2:0] M_DISPATCH = 3'd3;
  localparam logic [2:0] M_COMPLETE = 3'd4;
  localparam logic [2:0] M_READ     = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STATE    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  // flag bit positions
  localparam int F_INIT    = 0;
  localparam int F_QUEUED  = 1;
  localparam int F_RUNNING = 2;
  localparam int F_CANCEL  = 3;
  localparam int F_RERUN   = 4;

  // global counters
  localparam int G_SCHED  = 0;
  localparam int G_DISP   = 1;
  localparam int G_COAL   = 2;
  localparam int G_RERUN  = 3;
  localparam int G_CANCEL = 4;
  localparam int G_REJ    = 5;
  localparam int G_PEAK   = 6;
  localparam int G_CTX    = 7;
  localparam int G_RUN    = 8;
  localparam int G_COUNT  = 9;

  // per-line counters
  localparam int L_SCHED  = 0;
  localparam int L_DISP   = 1;
  localparam int L_COAL   = 2;
  localparam int L_REJ    = 3;
  localparam int L_CANCEL = 4;
  localparam int L_COUNT  = 5;

  localparam int OP_BITS = G_COUNT + L_COUNT;

  localparam logic [3:0] SEL_LAST_GLOBAL = 4'd8;
  localparam logic [3:0] SEL_LAST_LINE   = 4'd13;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] work_id;
    logic [7:0] line_id;
    logic [3:0] counter_select;
    logic       irq_enable;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_status;
    logic        dispatch_valid;
    logic [3:0]  dispatch_work;
    logic [4:0]  queued_count;
    logic [31:0] counter_value;
  } out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       rd_head;
    logic       cmp_start;
    logic [3:0] id;
  } ring_cmd_t;

  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_INC  = 2'd1,
    CK_DEC  = 2'd2,
    CK_MAX  = 2'd3
  } ctr_kind_t;

  typedef struct packed {
    logic      go;
    ctr_kind_t kind;
  } ctr_cmd_t;

  typedef struct packed {
    logic clearing;
    logic done;
  } ctr_sts_t;

endpackage

### hw/rtl/dwq_ring.sv
// ---------------------------------------------------------------------------
// dwq_ring
// Ring of slot numbers with head/tail/count and an in-order compaction walk.
// ---------------------------------------------------------------------------
module dwq_ring #(
  parameter int RING_DEPTH = 16,
  parameter int PW         = $clog2(RING_DEPTH),
  parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  dwq_pkg::ring_cmd_t  cmd,
  output logic [3:0]          rdata,
  output logic                cmp_done,
  output logic [CNT_W-1:0]    count
);
  import dwq_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RD   = 3'b010,
    C_WR   = 3'b100
  } cmp_state_t;

  logic [3:0]       mem [RING_DEPTH];
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] kept;
  logic [3:0]       cid;
  cmp_state_t       cs;

  function automatic logic [PW-1:0] wrap(input logic [PW:0] s);
    if (s >= (PW+1)'(RING_DEPTH)) return PW'(s - (PW+1)'(RING_DEPTH));
    return PW'(s);
  endfunction

  logic [PW-1:0] rd_idx;
  logic [PW-1:0] wr_idx;
  logic          keep_it;

  assign rd_idx  = wrap((PW+1)'(head) + (PW+1)'(i));
  assign wr_idx  = wrap((PW+1)'(head) + (PW+1)'(kept));
  assign keep_it = (rdata != cid);

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      cs       <= C_IDLE;
      cmp_done <= 1'b0;
      i        <= '0;
      kept     <= '0;
      cid      <= '0;
    end else begin
      cmp_done <= 1'b0;
      if (cmd.push) begin
        tail  <= wrap((PW+1)'(tail) + (PW+1)'(1));
        count <= count + CNT_W'(1);
      end
      if (cmd.pop) begin
        head  <= wrap((PW+1)'(head) + (PW+1)'(1));
        count <= count - CNT_W'(1);
      end
      case (cs)
        C_IDLE: begin
          if (cmd.cmp_start) begin
            i    <= '0;
            kept <= '0;
            cid  <= cmd.id;
            cs   <= C_RD;
          end
        end
        C_RD: begin
          if (i == count) begin
            count    <= kept;
            tail     <= wr_idx;
            cmp_done <= 1'b1;
            cs       <= C_IDLE;
          end else begin
            cs <= C_WR;
          end
        end
        C_WR: begin
          if (keep_it) kept <= kept + CNT_W'(1);
          i  <= i + CNT_W'(1);
          cs <= C_RD;
        end
        default: cs <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.id;
    end else if (cs == C_WR && keep_it) begin
      mem[wr_idx] <= rdata;
    end
    if (cmd.rd_head) begin
      rdata <= mem[head];
    end else if (cs == C_RD) begin
      rdata <= mem[rd_idx];
    end
  end

endmodule

### hw/rtl/dwq_ctr.sv
// ---------------------------------------------------------------------------
// dwq_ctr
// Counter store with one shared read-modify-write update unit.
// ---------------------------------------------------------------------------
module dwq_ctr #(
  parameter int LINE_COUNT = 16,
  parameter int CNT_W      = 5,
  parameter int CD         = 9 + LINE_COUNT * 5,
  parameter int AW         = $clog2(CD)
) (
  input  logic               clk,
  input  logic               rst,
  input  dwq_pkg::ctr_cmd_t  cmd,
  input  logic [AW-1:0]      addr,
  input  logic [CNT_W-1:0]   arg,
  output logic [31:0]        rdata,
  output dwq_pkg::ctr_sts_t  sts
);
  import dwq_pkg::*;

  logic [31:0]      mem [CD];
  logic             clearing;
  logic [AW-1:0]    clr_idx;
  logic             upd;
  logic [AW-1:0]    upd_addr;
  ctr_kind_t        upd_kind;
  logic [CNT_W-1:0] upd_arg;
  logic [31:0]      nv;

  always_comb begin
    case (upd_kind)
      CK_INC:  nv = rdata + 32'd1;
      CK_DEC:  nv = (rdata == 32'd0) ? 32'd0 : rdata - 32'd1;
      CK_MAX:  nv = (32'(upd_arg) > rdata) ? 32'(upd_arg) : rdata;
      default: nv = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      upd      <= 1'b0;
    end else begin
      upd <= cmd.go;
      if (clearing) begin
        if (clr_idx == AW'(CD - 1)) clearing <= 1'b0;
        else clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rdata    <= mem[addr];
      upd_addr <= addr;
      upd_kind <= cmd.kind;
      upd_arg  <= arg;
    end
    if (clearing) begin
      mem[clr_idx] <= 32'd0;
    end else if (upd && upd_kind != CK_NONE) begin
      mem[upd_addr] <= nv;
    end
  end

  assign sts.clearing = clearing;
  assign sts.done     = upd;

endmodule

### hw/rtl/deferred_work_queue_top.sv
// ---------------------------------------------------------------------------
// deferred_work_queue_top
// Deferred work queue: ring of slot numbers, per-slot flags and counters.
// ---------------------------------------------------------------------------
// Usage: raise start with an operation on req while busy is low; the
// transaction is taken at that edge and busy stays high until its result.
// Exactly one result per transaction appears on rsp for one cycle, marked
// by done; the receiver cannot stall, so it must sample rsp when done is high.
// Operations: every counter update goes through the single counter
// read-modify-write port (schedule does up to three, complete up to six).
// Cancel of a queued slot walks the ring one entry at a time. Dispatch
// reads and pops the ring head, cancelled entries being skipped.
// Sequencing: one transaction at a time; busy drops the cycle after done.
// Reset: flags, pointers and counts clear at once; the counter store then
// sweeps itself to zero with busy held high.
// ---------------------------------------------------------------------------
module deferred_work_queue_top #(
  parameter int RING_DEPTH   = dwq_pkg::DEF_RING_DEPTH,
  parameter int USABLE_DEPTH = dwq_pkg::DEF_USABLE_DEPTH,
  parameter int LINE_COUNT   = dwq_pkg::DEF_LINE_COUNT,
  parameter int WORK_SLOTS   = dwq_pkg::DEF_WORK_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dwq_pkg::in_t  req,
  output logic          busy,
  output logic          done,
  output dwq_pkg::out_t rsp
);
  import dwq_pkg::*;

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int CAP   = (USABLE_DEPTH < RING_DEPTH) ? USABLE_DEPTH : RING_DEPTH;
  localparam int CD    = G_COUNT + LINE_COUNT * L_COUNT;
  localparam int AW    = $clog2(CD);
  localparam int WIW   = (WORK_SLOTS > 1) ? $clog2(WORK_SLOTS) : 1;
  localparam int OPW   = $clog2(OP_BITS);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECIDE   = 10'b0000000010,
    S_CMP      = 10'b0000000100,
    S_DSP_RD   = 10'b0000001000,
    S_DSP_CHK  = 10'b0000010000,
    S_CTR      = 10'b0000100000,
    S_CTR_WAIT = 10'b0001000000,
    S_RDC      = 10'b0010000000,
    S_RDC_WAIT = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t             state;
  in_t                item;
  logic [4:0]         flags [WORK_SLOTS];
  logic [7:0]         lines [WORK_SLOTS];
  logic [OP_BITS-1:0] op_mask;
  logic               run_dec;
  logic [7:0]         bline;
  logic [2:0]         status;
  logic               dvalid;
  logic [3:0]         dwork;
  logic [31:0]        cval;
  logic [AW-1:0]      rd_addr;

  ring_cmd_t          rcmd;
  logic [3:0]         ring_rdata;
  logic               cmp_done;
  logic [CNT_W-1:0]   count;
  ctr_cmd_t           ccmd;
  logic [AW-1:0]      caddr;
  logic [31:0]        crdata;
  ctr_sts_t           csts;

  // decision on the latched item
  logic [WIW-1:0]     widx;
  logic [4:0]         f;
  logic               wok;
  logic               line_ok;
  logic               bump_ok;
  logic [2:0]         d_status;
  logic [4:0]         d_flags;
  logic               d_flags_we;
  logic               d_line_we;
  logic [OP_BITS-1:0] d_mask;
  logic               d_push;
  logic               d_cmp;
  logic               d_run_dec;
  logic               d_read;
  state_t             d_next;
  logic [AW-1:0]      d_rd_addr;

  assign widx    = WIW'(item.work_id);
  assign f       = flags[widx];
  assign wok     = 32'(item.work_id) < WORK_SLOTS;
  assign line_ok = 32'(item.line_id) < LINE_COUNT;
  assign bump_ok = 32'(lines[widx]) < LINE_COUNT;

  always_comb begin
    d_status   = ST_OK;
    d_flags    = f;
    d_flags_we = 1'b0;
    d_line_we  = 1'b0;
    d_mask     = '0;
    d_push     = 1'b0;
    d_cmp      = 1'b0;
    d_run_dec  = 1'b0;
    d_read     = 1'b0;
    d_next     = S_CTR;
    d_rd_addr  = '0;
    case (item.mode)
      M_INIT: begin
        if (!wok || (!line_ok && item.line_id != NO_LINE)) begin
          d_status = ST_INVALID;
        end else if (f[F_QUEUED] || f[F_RUNNING]) begin
          d_status = ST_STATE;
        end else begin
          d_line_we  = 1'b1;
          d_flags_we = 1'b1;
          d_flags    = 5'b0;
          d_flags[F_INIT] = 1'b1;
        end
      end
      M_SCHEDULE: begin
        if (!wok) begin
          d_status = ST_INVALID;
        end else if (!f[F_INIT]) begin
          d_status = ST_STATE;
        end else if (f[F_QUEUED] || f[F_RUNNING]) begin
          d_flags_we = 1'b1;
          if (!f[F_QUEUED]) d_flags[F_RERUN] = 1'b1;
          d_mask[G_COAL]           = 1'b1;
          d_mask[G_COUNT + L_COAL] = bump_ok;
        end else if (32'(count) >= CAP) begin
          d_status = ST_OVERFLOW;
          d_mask[G_REJ]           = 1'b1;
          d_mask[G_COUNT + L_REJ] = bump_ok;
        end else begin
          d_flags_we = 1'b1;
          d_flags[F_CANCEL] = 1'b0;
          d_flags[F_QUEUED] = 1'b1;
          d_push = 1'b1;
          d_mask[G_SCHED]           = 1'b1;
          d_mask[G_PEAK]            = 1'b1;
          d_mask[G_COUNT + L_SCHED] = bump_ok;
        end
      end
      M_CANCEL: begin
        if (!wok) begin
          d_status = ST_INVALID;
        end else if (!f[F_INIT]) begin
          d_status = ST_STATE;
        end else if (!f[F_QUEUED] && !f[F_RUNNING]) begin
          d_status = ST_NOTFOUND;
        end else begin
          d_flags_we = 1'b1;
          if (f[F_QUEUED]) begin
            d_flags[F_QUEUED] = 1'b0;
            d_flags[F_CANCEL] = 1'b0;
            d_cmp  = 1'b1;
            d_next = S_CMP;
          end else begin
            d_flags[F_CANCEL] = 1'b1;
          end
          d_flags[F_RERUN] = 1'b0;
          d_mask[G_CANCEL]           = 1'b1;
          d_mask[G_COUNT + L_CANCEL] = bump_ok;
        end
      end
      M_DISPATCH: begin
        if (!item.irq_enable) begin
          d_status = ST_STATE;
          d_mask[G_CTX] = 1'b1;
        end else if (count != '0) begin
          d_next = S_DSP_RD;
        end
      end
      M_COMPLETE: begin
        if (!wok) begin
          d_status = ST_INVALID;
        end else if (!f[F_INIT] || !f[F_RUNNING]) begin
          d_status = ST_STATE;
        end else begin
          d_flags_we = 1'b1;
          d_flags[F_RUNNING] = 1'b0;
          d_run_dec = 1'b1;
          d_mask[G_RUN]            = 1'b1;
          d_mask[G_DISP]           = 1'b1;
          d_mask[G_COUNT + L_DISP] = bump_ok;
          if (f[F_RERUN] && !f[F_CANCEL]) begin
            d_flags[F_RERUN] = 1'b0;
            if (32'(count) < CAP) begin
              d_flags[F_QUEUED] = 1'b1;
              d_push = 1'b1;
              d_mask[G_SCHED]           = 1'b1;
              d_mask[G_RERUN]           = 1'b1;
              d_mask[G_COUNT + L_SCHED] = bump_ok;
            end else begin
              d_status = ST_OVERFLOW;
              d_mask[G_REJ]           = 1'b1;
              d_mask[G_COUNT + L_REJ] = bump_ok;
            end
          end else begin
            d_flags[F_RERUN]  = 1'b0;
            d_flags[F_CANCEL] = 1'b0;
          end
        end
      end
      M_READ: begin
        if (item.counter_select <= SEL_LAST_GLOBAL) begin
          d_read    = 1'b1;
          d_rd_addr = AW'(item.counter_select);
        end else if (item.counter_select <= SEL_LAST_LINE && line_ok) begin
          d_read    = 1'b1;
          d_rd_addr = AW'(G_COUNT) + AW'(item.line_id) * AW'(L_COUNT)
                    + AW'(item.counter_select - 4'(G_COUNT));
        end else begin
          d_status = ST_INVALID;
        end
        if (d_read) d_next = S_RDC;
      end
      default: d_status = ST_INVALID;
    endcase
  end

  // lowest pending counter update
  logic [OPW-1:0] op_idx;
  always_comb begin
    op_idx = '0;
    for (int k = OP_BITS - 1; k >= 0; k--) begin
      if (op_mask[k]) op_idx = OPW'(k);
    end
  end

  logic [AW-1:0] op_addr;
  ctr_kind_t     op_kind;
  always_comb begin
    if (32'(op_idx) < G_COUNT) begin
      op_addr = AW'(op_idx);
    end else begin
      op_addr = AW'(G_COUNT) + AW'(bline) * AW'(L_COUNT)
              + AW'(op_idx - OPW'(G_COUNT));
    end
    if (32'(op_idx) == G_PEAK) op_kind = CK_MAX;
    else if (32'(op_idx) == G_RUN && run_dec) op_kind = CK_DEC;
    else op_kind = CK_INC;
  end

  // dispatch: popped slot
  logic [WIW-1:0] vidx;
  logic [4:0]     fv;
  logic [4:0]     fv_next;
  assign vidx = WIW'(ring_rdata);
  assign fv   = flags[vidx];

  always_comb begin
    fv_next = fv;
    fv_next[F_QUEUED] = 1'b0;
    if (fv[F_CANCEL]) begin
      fv_next[F_RUNNING] = 1'b0;
      fv_next[F_CANCEL]  = 1'b0;
    end else begin
      fv_next[F_RUNNING] = 1'b1;
    end
  end

  always_comb begin
    rcmd.push      = (state == S_DECIDE) && d_push;
    rcmd.cmp_start = (state == S_DECIDE) && d_cmp;
    rcmd.rd_head   = (state == S_DSP_RD);
    rcmd.pop       = (state == S_DSP_CHK);
    rcmd.id        = item.work_id;
    ccmd.go        = ((state == S_CTR) && (op_mask != '0)) || (state == S_RDC);
    ccmd.kind      = (state == S_RDC) ? CK_NONE : op_kind;
    caddr          = (state == S_RDC) ? rd_addr : op_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op_mask <= '0;
      for (int k = 0; k < WORK_SLOTS; k++) begin
        flags[k] <= '0;
        lines[k] <= NO_LINE;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            item   <= req;
            dvalid <= 1'b0;
            dwork  <= '0;
            cval   <= '0;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          status  <= d_status;
          op_mask <= d_mask;
          run_dec <= d_run_dec;
          bline   <= lines[widx];
          rd_addr <= d_rd_addr;
          if (d_flags_we) flags[widx] <= d_flags;
          if (d_line_we) lines[widx] <= item.line_id;
          state <= d_next;
        end
        S_CMP: begin
          if (cmp_done) state <= S_CTR;
        end
        S_DSP_RD: state <= S_DSP_CHK;
        S_DSP_CHK: begin
          flags[vidx] <= fv_next;
          if (fv[F_CANCEL]) begin
            state <= (count > CNT_W'(1)) ? S_DSP_RD : S_DONE;
          end else begin
            dvalid           <= 1'b1;
            dwork            <= ring_rdata;
            op_mask[G_RUN]   <= 1'b1;
            run_dec          <= 1'b0;
            state            <= S_CTR;
          end
        end
        S_CTR: begin
          state <= (op_mask != '0) ? S_CTR_WAIT : S_DONE;
        end
        S_CTR_WAIT: begin
          if (csts.done) begin
            op_mask[op_idx] <= 1'b0;
            state <= S_CTR;
          end
        end
        S_RDC: state <= S_RDC_WAIT;
        S_RDC_WAIT: begin
          if (csts.done) begin
            cval  <= crdata;
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE) || csts.clearing;
  assign done = (state == S_DONE);

  always_comb begin
    rsp.result_status  = status;
    rsp.dispatch_valid = dvalid;
    rsp.dispatch_work  = dwork;
    rsp.queued_count   = 5'(count);
    rsp.counter_value  = cval;
  end

  dwq_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (rcmd),
    .rdata   (ring_rdata),
    .cmp_done(cmp_done),
    .count   (count)
  );

  dwq_ctr #(
    .LINE_COUNT(LINE_COUNT),
    .CNT_W     (CNT_W)
  ) u_ctr (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ccmd),
    .addr (caddr),
    .arg  (count),
    .rdata(crdata),
    .sts  (csts)
  );

  // accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");

  // ring holds no more than the usable depth whenever a result is done
  a_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(count) <= CAP))
    else $error("ring holds more than its usable depth");

  // a popped slot is only reported with a good status
  a_disp_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.dispatch_valid) |-> (rsp.result_status == ST_OK))
    else $error("dispatch reported with error status");

  // counter store is not touched by the sequencer while it is clearing
  a_no_go_clear: assert property (@(posedge clk) disable iff (rst)
    csts.clearing |-> !ccmd.go)
    else $error("counter access during clearing sweep");

endmodule
